FILE: hw/rtl/salsa_pkg.sv
// Shared types and constants for the Salsa20 stream cipher block.
`default_nettype none

package salsa_pkg;

    // Number of double rounds per keystream block.
    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUND_W       = $clog2(DOUBLE_ROUNDS);

    // Depth of the input word queue; must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 8;

    // Diagonal constants: "expand 32-byte k" and "expand 16-byte k".
    localparam logic [31:0] SIGMA [4] = '{32'h61707865, 32'h3320646e,
                                          32'h79622d32, 32'h6b206574};
    localparam logic [31:0] TAU   [4] = '{32'h61707865, 32'h3120646e,
                                          32'h79622d36, 32'h6b206574};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0   = 8'd0,
        CFG_KEY_1   = 8'd1,
        CFG_KEY_2   = 8'd2,
        CFG_KEY_3   = 8'd3,
        CFG_KEY_256 = 8'd4,
        CFG_NONCE   = 8'd5
    } cfg_idx_t;

    // Sixteen-word Salsa20 state.
    typedef logic [31:0] words_t [16];

    // Configuration register contents.
    typedef struct packed {
        logic [63:0] key_0;
        logic [63:0] key_1;
        logic [63:0] key_2;
        logic [63:0] key_3;
        logic        key_256;
        logic [63:0] nonce;
    } cfg_t;

    // One queued input word.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
    } item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/salsa_in_queue.sv
// Front end: accepts input words and queues them for the keystream XOR stage.
`default_nettype none

module salsa_in_queue
    import salsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,
    output logic             q_valid,
    output item_t            q_item,
    input  wire logic        q_pop
);

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                push;
    logic                pop;

    assign s_axis_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid       = (count_reg != '0);
    assign q_item        = mem_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_pop && q_valid;

    // Storage for queued words.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{in_byte: s_axis_tdata, last_in: s_axis_tlast};
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/salsa_core.sv
// Keystream generator: runs the Salsa20 rounds and holds one finished block.
`default_nettype none

module salsa_core
    import salsa_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  cfg_t        cfg,
    input  wire logic   flush,
    output logic        blk_valid,
    output words_t      blk_words,
    input  wire logic   blk_take
);

    // Quarter-round word indexes {a, b, c, d}: column round, then row round.
    localparam logic [3:0] QR_IDX [2][4][4] = '{
        '{'{4'd0,  4'd4,  4'd8,  4'd12}, '{4'd5,  4'd9,  4'd13, 4'd1},
          '{4'd10, 4'd14, 4'd2,  4'd6},  '{4'd15, 4'd3,  4'd7,  4'd11}},
        '{'{4'd0,  4'd1,  4'd2,  4'd3},  '{4'd5,  4'd6,  4'd7,  4'd4},
          '{4'd10, 4'd11, 4'd8,  4'd9},  '{4'd15, 4'd12, 4'd13, 4'd14}}
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t              state_reg;
    words_t              x_reg;
    words_t              pend_reg;
    logic                pend_valid_reg;
    logic [ROUND_W-1:0]  round_reg;
    logic [1:0]          step_reg;
    logic [63:0]         ctr_reg;
    words_t              init_words;
    words_t              step_words;
    logic                last_step;
    logic                pend_write;

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
        return (v << n) | (v >> (6'd32 - {1'b0, n}));
    endfunction

    // Half of a column or row round: two add-rotate-xor steps per quarter round.
    function automatic words_t half_round(input words_t x, input logic row,
                                          input logic second);
        words_t     y;
        logic [3:0] ia;
        logic [3:0] ib;
        logic [3:0] ic;
        logic [3:0] id;
        y = x;
        for (int q = 0; q < 4; q++)
        begin
            ia = QR_IDX[row][q][0];
            ib = QR_IDX[row][q][1];
            ic = QR_IDX[row][q][2];
            id = QR_IDX[row][q][3];
            if (!second)
            begin
                y[ib] = y[ib] ^ rotl(y[ia] + y[id], 5'd7);
                y[ic] = y[ic] ^ rotl(y[ib] + y[ia], 5'd9);
            end
            else
            begin
                y[id] = y[id] ^ rotl(y[ic] + y[ib], 5'd13);
                y[ia] = y[ia] ^ rotl(y[id] + y[ic], 5'd18);
            end
        end
        return y;
    endfunction

    // Input state of the block from key, nonce and counter.
    always_comb
    begin
        init_words[0]  = cfg.key_256 ? SIGMA[0] : TAU[0];
        init_words[1]  = cfg.key_0[31:0];
        init_words[2]  = cfg.key_0[63:32];
        init_words[3]  = cfg.key_1[31:0];
        init_words[4]  = cfg.key_1[63:32];
        init_words[5]  = cfg.key_256 ? SIGMA[1] : TAU[1];
        init_words[6]  = cfg.nonce[31:0];
        init_words[7]  = cfg.nonce[63:32];
        init_words[8]  = ctr_reg[31:0];
        init_words[9]  = ctr_reg[63:32];
        init_words[10] = cfg.key_256 ? SIGMA[2] : TAU[2];
        init_words[11] = cfg.key_256 ? cfg.key_2[31:0]  : cfg.key_0[31:0];
        init_words[12] = cfg.key_256 ? cfg.key_2[63:32] : cfg.key_0[63:32];
        init_words[13] = cfg.key_256 ? cfg.key_3[31:0]  : cfg.key_1[31:0];
        init_words[14] = cfg.key_256 ? cfg.key_3[63:32] : cfg.key_1[63:32];
        init_words[15] = cfg.key_256 ? SIGMA[3] : TAU[3];
    end

    assign step_words = half_round(x_reg, step_reg[1], step_reg[0]);
    assign last_step  = (step_reg == 2'd3) && (round_reg == ROUND_W'(DOUBLE_ROUNDS - 1));
    assign pend_write = (state_reg == ST_HOLD) && (!pend_valid_reg || blk_take);

    assign blk_valid = pend_valid_reg;
    assign blk_words = pend_reg;

    // Round datapath and finished-block register.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE: x_reg <= init_words;
            ST_RUN:  x_reg <= step_words;
            default: x_reg <= x_reg;
        endcase
        if (pend_write)
        begin
            for (int i = 0; i < 16; i++)
            begin
                pend_reg[i] <= x_reg[i] + init_words[i];
            end
        end
    end

    // Sequencer, block counter and pending flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            round_reg      <= '0;
            step_reg       <= '0;
            ctr_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (flush)
        begin
            state_reg      <= ST_IDLE;
            round_reg      <= '0;
            step_reg       <= '0;
            ctr_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (blk_take)
            begin
                pend_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    round_reg <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (last_step)
                    begin
                        state_reg <= ST_HOLD;
                    end
                    else if (step_reg == 2'd3)
                    begin
                        round_reg <= round_reg + 1'b1;
                    end
                end
                ST_HOLD:
                begin
                    if (pend_write)
                    begin
                        pend_valid_reg <= 1'b1;
                        ctr_reg        <= ctr_reg + 64'd1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/salsa_xor_out.sv
// Back end: current keystream block, byte XOR and output register.
`default_nettype none

module salsa_xor_out
    import salsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        flush,
    input  wire logic        q_valid,
    input  item_t            q_item,
    output logic             q_pop,
    input  wire logic        blk_valid,
    input  words_t           blk_words,
    output logic             blk_take,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast
);

    words_t       cur_reg;
    logic [6:0]   pos_reg;       // 64 means the current block is used up
    logic         out_valid_reg;
    logic [7:0]   out_byte_reg;
    logic         out_last_reg;
    logic         have_ks;
    logic         out_free;
    logic         fire;
    logic [31:0]  cur_word;
    logic [7:0]   ks_byte;

    assign have_ks  = !pos_reg[6] || blk_valid;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign fire     = q_valid && have_ks && out_free;
    assign q_pop    = fire;
    assign blk_take = fire && pos_reg[6];

    // Next keystream byte: byte 0 of the pending block once the current one is used up.
    assign cur_word = cur_reg[pos_reg[5:2]];
    assign ks_byte  = pos_reg[6] ? blk_words[0][7:0] : cur_word[8*pos_reg[1:0] +: 8];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    // Block and output payload.
    always_ff @(posedge clk)
    begin
        if (blk_take)
        begin
            cur_reg <= blk_words;
        end
        if (fire)
        begin
            out_byte_reg <= q_item.in_byte ^ ks_byte;
            out_last_reg <= q_item.last_in;
        end
    end

    // Byte position and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 7'd64;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (flush)
            begin
                pos_reg <= 7'd64;
            end
            else if (fire)
            begin
                pos_reg <= pos_reg[6] ? 7'd1 : pos_reg + 7'd1;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/salsa20_stream_cipher.sv
// Top level of the Salsa20 stream cipher: configuration registers and block wiring.
//
// Each input word (one byte and its last flag) is XORed with the next Salsa20
// keystream byte and leaves as one output word, one word per cycle sustained
// while the receiver is ready. The generator takes one step per half of a column
// or row round, so a 64-byte keystream block is made by a load, 40 round steps
// and a feed-forward add; it works one block ahead of the byte being used, which
// keeps up with one byte per cycle. After reset or after a write to a known
// register the first byte waits for its block to be made. Such a write restarts
// the block counter at zero and drops any keystream already made; write registers
// only while no words are in flight. Writes to indexes beyond the nonce are
// ignored. The input queue holds four words.
`default_nettype none

module salsa20_stream_cipher
    import salsa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] in_byte
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [7:0] out_byte
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]           cfg_data
);

    cfg_t    cfg_reg;
    logic    cfg_hit;
    logic    flush;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    logic    blk_valid;
    words_t  blk_words;
    logic    blk_take;

    assign cfg_ready = 1'b1;

    // Decode the register index; only known registers restart the stream.
    always_comb
    begin
        unique case (cfg_index)
            CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3, CFG_KEY_256, CFG_NONCE:
                cfg_hit = 1'b1;
            default:
                cfg_hit = 1'b0;
        endcase
    end

    assign flush = cfg_valid && cfg_hit;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KEY_0:   cfg_reg.key_0   <= cfg_data;
                CFG_KEY_1:   cfg_reg.key_1   <= cfg_data;
                CFG_KEY_2:   cfg_reg.key_2   <= cfg_data;
                CFG_KEY_3:   cfg_reg.key_3   <= cfg_data;
                CFG_KEY_256: cfg_reg.key_256 <= cfg_data[0];
                CFG_NONCE:   cfg_reg.nonce   <= cfg_data;
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    salsa_in_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    salsa_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .flush     (flush),
        .blk_valid (blk_valid),
        .blk_words (blk_words),
        .blk_take  (blk_take)
    );

    salsa_xor_out u_xor (
        .clk           (clk),
        .rst_n         (rst_n),
        .flush         (flush),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .blk_valid     (blk_valid),
        .blk_words     (blk_words),
        .blk_take      (blk_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: sim/tb_salsa20_stream_cipher.sv
// Self-checking testbench for the Salsa20 stream cipher block.
`timescale 1ns / 1ps

module tb_salsa20_stream_cipher;
    import salsa_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int BLOCK_BYTES   = 64;
    // Longer than one keystream block takes to generate.
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int STUCK_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_WORDS   = 250;

    // Diagonal words, word 0 in the lowest bits.
    localparam logic [127:0] EXPAND_32 = {32'h6b206574, 32'h79622d32,
                                          32'h3320646e, 32'h61707865};
    localparam logic [127:0] EXPAND_16 = {32'h6b206574, 32'h79622d36,
                                          32'h3120646e, 32'h61707865};

    // Register indexes that the block must ignore.
    localparam logic [CFG_IDX_W-1:0] IDX_PAST_END = CFG_IDX_W'(CFG_NONCE + 1);
    localparam logic [CFG_IDX_W-1:0] IDX_TOP      = '1;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } cipher_word_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [7:0] in_byte
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // [7:0] out_byte
    logic                 m_axis_tlast;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [63:0]          cfg_data      = '0;

    // Shadow copy of the cipher state.
    logic [63:0]  key_w [4];
    logic         wide_key;
    logic [63:0]  iv_word;
    logic [63:0]  blk_count;
    logic [7:0]   ks_bytes [BLOCK_BYTES];
    int           ks_next;
    logic [31:0]  mix_w [16];

    cipher_word_t expected_words [$];
    int           fail_count   = 0;
    int           stuck_cycles = 0;
    bit           hold_request = 1'b0;

    salsa20_stream_cipher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // One quarter round on the shared working words.
    function automatic void quarter_round(input int a, input int b, input int c, input int d);
        mix_w[b] ^= rotl32(mix_w[a] + mix_w[d], 7);
        mix_w[c] ^= rotl32(mix_w[b] + mix_w[a], 9);
        mix_w[d] ^= rotl32(mix_w[c] + mix_w[b], 13);
        mix_w[a] ^= rotl32(mix_w[d] + mix_w[c], 18);
    endfunction

    // Build the next 64 keystream bytes and advance the block counter.
    function automatic void make_keystream_block();
        logic [31:0]  init_w [16];
        logic [127:0] diag;
        logic [63:0]  hi_0;
        logic [63:0]  hi_1;
        logic [31:0]  sum;
        int           r;
        int           i;
        diag = wide_key ? EXPAND_32 : EXPAND_16;
        hi_0 = wide_key ? key_w[2] : key_w[0];
        hi_1 = wide_key ? key_w[3] : key_w[1];
        init_w[0]  = diag[31:0];
        init_w[1]  = key_w[0][31:0];
        init_w[2]  = key_w[0][63:32];
        init_w[3]  = key_w[1][31:0];
        init_w[4]  = key_w[1][63:32];
        init_w[5]  = diag[63:32];
        init_w[6]  = iv_word[31:0];
        init_w[7]  = iv_word[63:32];
        init_w[8]  = blk_count[31:0];
        init_w[9]  = blk_count[63:32];
        init_w[10] = diag[95:64];
        init_w[11] = hi_0[31:0];
        init_w[12] = hi_0[63:32];
        init_w[13] = hi_1[31:0];
        init_w[14] = hi_1[63:32];
        init_w[15] = diag[127:96];
        for (i = 0; i < 16; i++)
            mix_w[i] = init_w[i];
        for (r = 0; r < DOUBLE_ROUNDS; r++)
        begin
            quarter_round(0, 4, 8, 12);
            quarter_round(5, 9, 13, 1);
            quarter_round(10, 14, 2, 6);
            quarter_round(15, 3, 7, 11);
            quarter_round(0, 1, 2, 3);
            quarter_round(5, 6, 7, 4);
            quarter_round(10, 11, 8, 9);
            quarter_round(15, 12, 13, 14);
        end
        // Feed-forward add, serialized little-endian.
        for (i = 0; i < 16; i++)
        begin
            sum = mix_w[i] + init_w[i];
            ks_bytes[4*i]     = sum[7:0];
            ks_bytes[4*i + 1] = sum[15:8];
            ks_bytes[4*i + 2] = sum[23:16];
            ks_bytes[4*i + 3] = sum[31:24];
        end
        blk_count += 64'd1;
        ks_next = 0;
    endfunction

    function automatic void reset_cipher_state();
        int i;
        for (i = 0; i < 4; i++)
            key_w[i] = '0;
        wide_key  = 1'b0;
        iv_word   = '0;
        blk_count = '0;
        ks_next   = BLOCK_BYTES;
    endfunction

    // Register update; any known register restarts the keystream.
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [63:0] val);
        bit known;
        known = 1'b1;
        case (idx)
            CFG_KEY_0:   key_w[0] = val;
            CFG_KEY_1:   key_w[1] = val;
            CFG_KEY_2:   key_w[2] = val;
            CFG_KEY_3:   key_w[3] = val;
            CFG_KEY_256: wide_key = val[0];
            CFG_NONCE:   iv_word  = val;
            default:     known = 1'b0;
        endcase
        if (known)
        begin
            blk_count = '0;
            ks_next   = BLOCK_BYTES;
        end
    endfunction

    // Expected output word for one accepted input word.
    function automatic void encrypt_word(input logic [7:0] b, input logic l);
        cipher_word_t w;
        if (ks_next >= BLOCK_BYTES)
            make_keystream_block();
        w.out_byte = b ^ ks_bytes[ks_next];
        w.last_out = l;
        ks_next++;
        expected_words.push_back(w);
    endfunction

    // Offer one input word and wait until it is taken.
    task automatic send_word(input logic [7:0] b, input logic l);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        encrypt_word(b, l);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        apply_register(idx, val);
        @(posedge clk);
    endtask

    // Stop offering, wait for every expected word, then let the generator settle.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random messages sent in bursts with random gaps.
    task automatic send_stream(input int count);
        int burst;
        int gap;
        int msg_left;
        int i;
        burst    = $urandom_range(1, 40);
        msg_left = $urandom_range(1, 120);
        for (i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst = $urandom_range(1, 40);
            end
            send_word(8'($urandom_range(0, 255)), msg_left == 1);
            burst--;
            msg_left--;
            if (msg_left == 0)
                msg_left = ($urandom_range(7) == 0) ? 1 : $urandom_range(1, 120);
        end
    endtask

    // Reset state: all-zero key, 128-bit mode; the last flag does not break the stream.
    task automatic test_zero_key();
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'ha5, 1'b0);
        send_word(8'h5a, 1'b0);
        send_word(8'h01, 1'b1);
        send_word(8'h80, 1'b0);
        quiesce();
    endtask

    // 256-bit key with extreme values, then a wide value that leaves 256-bit mode.
    task automatic test_key_sizes();
        write_reg(CFG_KEY_0, '1);
        write_reg(CFG_KEY_1, {$urandom, $urandom});
        write_reg(CFG_KEY_2, '0);
        write_reg(CFG_KEY_3, '1);
        write_reg(CFG_KEY_256, 64'd1);
        write_reg(CFG_NONCE, '1);
        repeat (5) send_word(8'($urandom_range(0, 255)), 1'b0);
        quiesce();
        write_reg(CFG_KEY_256, ~64'd1);
        repeat (4) send_word(8'($urandom_range(0, 255)), 1'b0);
        send_word(8'hff, 1'b1);
        quiesce();
    endtask

    // Out-of-range writes keep the stream going; a real write restarts it.
    task automatic test_config_effects();
        write_reg(IDX_PAST_END, '1);
        write_reg(IDX_TOP, '1);
        repeat (3) send_word(8'($urandom_range(0, 255)), 1'b0);
        quiesce();
        write_reg(CFG_NONCE, iv_word);
        repeat (3) send_word(8'($urandom_range(0, 255)), 1'b1);
        quiesce();
    endtask

    // The receiver holds off long enough for the input side to back up.
    task automatic test_back_pressure();
        hold_request = 1'b1;
        repeat (48) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(1)));
        quiesce();
    endtask

    // The sender drains the block mid-stream and the keystream carries on.
    task automatic test_pause_resume();
        send_stream(100);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        send_stream(100);
        quiesce();
    endtask

    // Several settings, the extremes first, each followed by random traffic.
    task automatic test_random_phases();
        logic [63:0] val [6];
        int          phase;
        int          i;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (i = 0; i < 6; i++)
            begin
                case (phase)
                    0:       val[i] = '1;
                    1:       val[i] = '0;
                    default: val[i] = {$urandom, $urandom};
                endcase
            end
            write_reg(CFG_KEY_0, val[0]);
            write_reg(CFG_KEY_1, val[1]);
            write_reg(CFG_KEY_2, val[2]);
            write_reg(CFG_KEY_3, val[3]);
            write_reg(CFG_KEY_256, val[4]);
            write_reg(CFG_NONCE, val[5]);
            if ($urandom_range(1) == 1)
                write_reg(8'($urandom_range(IDX_PAST_END, IDX_TOP)), {$urandom, $urandom});
            send_stream(PHASE_WORDS);
            quiesce();
        end
    endtask

    // Receiver: stall rate changes every so often; on request a long hold.
    initial
    begin : receiver
        int stall_pct;
        int run_left;
        stall_pct = 0;
        run_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (run_left == 0)
            begin
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                run_left = $urandom_range(8, 120);
            end
            run_left--;
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each output word with the oldest expectation.
    always @(posedge clk)
    begin
        cipher_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected output word: out_byte %h last_out %b",
                       m_axis_tdata, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_axis_tdata !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last_out)
                begin
                    $error("last_out: expected %b, got %b", want.last_out, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any word moving on any channel.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        reset_cipher_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_key();
        test_key_sizes();
        test_config_effects();
        test_back_pressure();
        test_pause_resume();
        test_random_phases();

        quiesce();
        if (fail_count == 0 && expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
